FILE: hdl/mmts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max tracking stack package
// Sizes, entry layout, status codes and controller states shared by the
// stack, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package mmts_pkg;

  // Stack geometry and stored value width.
  localparam int STACK_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;

  // Widths of the beat fields and of the internal counters.
  localparam int FIELD_W = 32;
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int COUNT_W = 9;

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  // One stack entry: the value with the minimum and maximum at or below it.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] val;
    logic [VALUE_WIDTH-1:0] mn;
    logic [VALUE_WIDTH-1:0] mx;
  } entry_t;

endpackage

FILE: hdl/mmts_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one push or pop request per beat.
// ----------------------------------------------------------------------------
interface mmts_req_if;
  import mmts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [FIELD_W-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);

endinterface

FILE: hdl/mmts_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the stack summary after each request.
// ----------------------------------------------------------------------------
interface mmts_rsp_if;
  import mmts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] top_value;
  logic signed [FIELD_W-1:0] min_value;
  logic signed [FIELD_W-1:0] max_value;
  logic                      is_empty;
  logic [COUNT_W-1:0]        entry_count;
  logic [1:0]                status;

  modport source (output valid, top_value, min_value, max_value, is_empty,
                  entry_count, status, input ready);
  modport sink   (input valid, top_value, min_value, max_value, is_empty,
                  entry_count, status, output ready);

endinterface

FILE: hdl/mmts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmts_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/min_max_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max tracking stack
// Bounded stack of signed values that reports top, minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per beat: req_type selects push or pop, and
//   push_value is the value to push. rsp returns exactly one beat per
//   request with the new top, minimum, maximum, empty flag, entry count and
//   a status (pop on empty and push on full are reported and ignored).
// Timing:
//   The top entry lives in registers; all entries also live in one RAM with
//   a registered read. A push, a rejected request and a pop that empties
//   the stack finish in the accept cycle: the rsp beat is valid on the next
//   cycle, and another request can be taken then if rsp.ready is high. A
//   pop that leaves entries behind passes through S_POP to wait for the RAM
//   read of the new top, and takes no new request until it finishes.
// Reset:
//   rst clears the entry count and all handshake state; RAM contents are
//   left as they are and are only read after being written.
// Backpressure:
//   A finished beat waits in the output register while rsp.ready is low;
//   req.ready stays low until that register is free or being drained.
// ----------------------------------------------------------------------------
module min_max_tracking_stack (
  input logic         clk,
  input logic         rst,
  mmts_req_if.sink    req,
  mmts_rsp_if.source  rsp
);
  import mmts_pkg::*;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [VALUE_WIDTH-1:0] top_val;
  logic [VALUE_WIDTH-1:0] top_min;
  logic [VALUE_WIDTH-1:0] top_max;

  logic                   out_valid;
  logic [FIELD_W-1:0]     out_top;
  logic [FIELD_W-1:0]     out_min;
  logic [FIELD_W-1:0]     out_max;
  logic                   out_empty;
  logic [COUNT_W-1:0]     out_count;
  status_t                out_status;

  logic                   accept;
  logic                   is_pop;
  logic                   full;
  logic                   finish;
  logic [VALUE_WIDTH-1:0] raw;
  entry_t                 new_entry;
  entry_t                 rd_entry;
  logic                   wr_en;
  logic [CNT_W-1:0]       below_top;

  // Handshake: take a request only when idle and the output can be filled.
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign is_pop    = (req.req_type == REQ_POP);
  assign full      = (count == CNT_W'(STACK_DEPTH));

  // A beat is produced now unless a pop must wait for the RAM read.
  assign finish = (state == S_POP) ||
                  (accept && (!is_pop || (count <= CNT_W'(1))));

  // New entry from the pushed value and the current top.
  assign raw = VALUE_WIDTH'(req.push_value);
  always_comb begin
    new_entry.val = raw;
    new_entry.mn  = raw;
    new_entry.mx  = raw;
    if (count != '0) begin
      if ($signed(top_min) < $signed(raw)) begin
        new_entry.mn = top_min;
      end
      if ($signed(raw) < $signed(top_max)) begin
        new_entry.mx = top_max;
      end
    end
  end

  // Entry storage: pushes write at count, pops read the entry under the top.
  assign wr_en     = accept && !is_pop && !full;
  assign below_top = count - CNT_W'(2);

  mmts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (new_entry),
    .rd_addr (below_top[ADDR_W-1:0]),
    .rd_data (rd_entry)
  );

  // Control state: controller, entry count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= finish || (out_valid && !rsp.ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_pop) begin
              if (count != '0) begin
                count <= count - CNT_W'(1);
                if (count != CNT_W'(1)) begin
                  state <= S_POP;
                end
              end
            end else if (!full) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        S_POP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: top-entry registers and the output beat.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_pop) begin
            // Every accepted pop; the beat is sent only for a pop on empty or a pop that empties the stack.
            out_top    <= '0;
            out_min    <= '0;
            out_max    <= '0;
            out_empty  <= 1'b1;
            out_count  <= '0;
            out_status <= (count == '0) ? ST_POP_EMPTY : ST_OK;
          end else if (full) begin
            // Rejected push reports the unchanged top.
            out_top    <= FIELD_W'(top_val);
            out_min    <= FIELD_W'(top_min);
            out_max    <= FIELD_W'(top_max);
            out_empty  <= 1'b0;
            out_count  <= COUNT_W'(count);
            out_status <= ST_PUSH_FULL;
          end else begin
            top_val    <= new_entry.val;
            top_min    <= new_entry.mn;
            top_max    <= new_entry.mx;
            out_top    <= FIELD_W'(new_entry.val);
            out_min    <= FIELD_W'(new_entry.mn);
            out_max    <= FIELD_W'(new_entry.mx);
            out_empty  <= 1'b0;
            out_count  <= COUNT_W'(count + CNT_W'(1));
            out_status <= ST_OK;
          end
        end
      end
      S_POP: begin
        // The entry under the old top arrives from the RAM.
        top_val    <= rd_entry.val;
        top_min    <= rd_entry.mn;
        top_max    <= rd_entry.mx;
        out_top    <= FIELD_W'(rd_entry.val);
        out_min    <= FIELD_W'(rd_entry.mn);
        out_max    <= FIELD_W'(rd_entry.mx);
        out_empty  <= 1'b0;
        out_count  <= COUNT_W'(count);
        out_status <= ST_OK;
      end
      default: begin
        out_status <= ST_OK;
      end
    endcase
  end

  // Output beat.
  assign rsp.valid       = out_valid;
  assign rsp.top_value   = out_top;
  assign rsp.min_value   = out_min;
  assign rsp.max_value   = out_max;
  assign rsp.is_empty    = out_empty;
  assign rsp.entry_count = out_count;
  assign rsp.status      = out_status;

endmodule

FILE: hdl/mmts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-max tracking stack checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module mmts_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [mmts_pkg::FIELD_W-1:0] top_value,
  input logic signed [mmts_pkg::FIELD_W-1:0] min_value,
  input logic signed [mmts_pkg::FIELD_W-1:0] max_value,
  input logic                               is_empty,
  input logic [mmts_pkg::COUNT_W-1:0]       entry_count,
  input logic [1:0]                         status
);
  import mmts_pkg::*;

  // A stalled beat stays valid with its entry count and status unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count) && $stable(status))
    else $error("response beat changed while stalled");

  // The empty flag agrees with the entry count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // An empty stack reports zero values.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> top_value == '0 && min_value == '0 && max_value == '0)
    else $error("empty stack reports nonzero values");

  // The top lies between the tracked minimum and maximum.
  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !is_empty |-> min_value <= top_value && top_value <= max_value)
    else $error("top outside minimum and maximum");

  // A rejected push only happens on a full stack.
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_PUSH_FULL |-> entry_count == COUNT_W'(STACK_DEPTH))
    else $error("push rejected on a stack that is not full");

endmodule

bind min_max_tracking_stack mmts_checker u_mmts_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .top_value   (rsp.top_value),
  .min_value   (rsp.min_value),
  .max_value   (rsp.max_value),
  .is_empty    (rsp.is_empty),
  .entry_count (rsp.entry_count),
  .status      (rsp.status)
);
